>>> rtl/at_response_matcher_top_macros.svh
// Assertion helpers shared by the matcher RTL.
// Both expect clk and rst_n in scope; checks are off while reset is low.
`ifndef AT_RESPONSE_MATCHER_TOP_MACROS_SVH
`define AT_RESPONSE_MATCHER_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ATRM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define ATRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/atrm_pkg.sv
`default_nettype none

package atrm_pkg;

    // sizing
    localparam int MAX_EXPECT   = 16;
    localparam int BUF_BYTES    = 512;
    localparam int EXP_SLOTS    = (MAX_EXPECT < 16) ? MAX_EXPECT : 16;
    localparam int ERR_MAX_LEN  = 10;
    localparam int WIN_DEPTH    = (EXP_SLOTS > ERR_MAX_LEN) ? EXP_SLOTS : ERR_MAX_LEN;
    localparam int CAPACITY     = BUF_BYTES - 1;
    localparam int CNT_W        = $clog2(BUF_BYTES);
    localparam int LEN_W        = 5;
    localparam int CMP_W        = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int TICK_W       = 32;
    localparam int SHOWN_W      = 9;
    localparam int SHOWN_MAX    = (1 << SHOWN_W) - 1;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W       = $clog2(QDEPTH + 1);
    localparam int DATA_W       = 64;
    localparam int ADDR_W       = 5;

    // input operation codes
    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // register indexes (byte address is 8 * index)
    localparam logic [1:0] REG_EXP_LO  = 2'd0;
    localparam logic [1:0] REG_EXP_HI  = 2'd1;
    localparam logic [1:0] REG_EXP_LEN = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // register reset values
    localparam logic [LEN_W-1:0]  EXP_LEN_RST = LEN_W'(2);
    localparam logic [TICK_W-1:0] TIMEOUT_RST = TICK_W'(1000);

    // fixed error replies, first character at index 0
    localparam int ERR_CRLF_LEN = 9;
    localparam int ERR_CMX_LEN  = 10;
    localparam logic [7:0] ERR_CRLF [ERR_CRLF_LEN] =
        '{8'h0D, 8'h0A, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h0D, 8'h0A};
    localparam logic [7:0] ERR_CME [ERR_CMX_LEN] =
        '{8'h2B, 8'h43, 8'h4D, 8'h45, 8'h20, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};
    localparam logic [7:0] ERR_CMS [ERR_CMX_LEN] =
        '{8'h2B, 8'h43, 8'h4D, 8'h53, 8'h20, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

    typedef enum logic [1:0] {
        V_PENDING = 2'd0,
        V_FOUND   = 2'd1,
        V_ERROR   = 2'd2,
        V_TIMEOUT = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        K_RESTART,
        K_BYTE,
        K_TICK,
        K_NOP
    } kind_t;

    // classified item as held in the queue
    typedef struct packed {
        kind_t      kind;
        logic [7:0] rx_byte;
    } item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef logic [EXP_SLOTS-1:0][7:0] pat_t;
    typedef logic [WIN_DEPTH-1:0][7:0] win_t;

    // prepared match settings
    typedef struct packed {
        pat_t               pat_rev;   // slot i holds expected byte len-1-i
        logic [EXP_SLOTS-1:0] mask;
        logic [LEN_W-1:0]   eff_len;
        logic [TICK_W-1:0]  timeout;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/atrm_ifs.sv
`default_nettype none

// request channel: operation plus received byte
interface atrm_item_if;
    import atrm_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] rx_byte;
    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// result channel: verdict plus stored byte count
interface atrm_result_if;
    import atrm_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         verdict;
    logic [SHOWN_W-1:0] stored_bytes;
    modport source (output valid, output verdict, output stored_bytes, input ready);
    modport sink   (input valid, input verdict, input stored_bytes, output ready);
endinterface

`default_nettype wire

>>> rtl/atrm_cfg.sv
`default_nettype none

module atrm_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [atrm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [atrm_pkg::DATA_W-1:0] pwdata,
    output logic      [atrm_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output atrm_pkg::cfg_t                  cfg
);
    import atrm_pkg::*;

    logic [DATA_W-1:0]    exp_lo_reg;
    logic [DATA_W-1:0]    exp_hi_reg;
    logic [LEN_W-1:0]     exp_len_reg;
    logic [TICK_W-1:0]    tmo_reg;
    logic [LEN_W-1:0]     eff_len_reg;
    logic [LEN_W-1:0]     eff_len_next;
    pat_t                 pat_reg;
    pat_t                 pat_next;
    logic [EXP_SLOTS-1:0] mask_reg;
    logic [EXP_SLOTS-1:0] mask_next;
    logic [15:0][7:0]     exp_b;
    logic [LEN_W-1:0]     lim;
    logic [LEN_W-1:0]     src_idx;
    logic [1:0]           reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;
    assign exp_b   = {exp_hi_reg, exp_lo_reg};

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_lo_reg  <= '0;
            exp_hi_reg  <= '0;
            exp_len_reg <= EXP_LEN_RST;
            tmo_reg     <= TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_EXP_LO:  exp_lo_reg  <= pwdata;
                REG_EXP_HI:  exp_hi_reg  <= pwdata;
                REG_EXP_LEN: exp_len_reg <= pwdata[LEN_W-1:0];
                REG_TIMEOUT: tmo_reg     <= pwdata[TICK_W-1:0];
                default:     ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_EXP_LO:  prdata = exp_lo_reg;
            REG_EXP_HI:  prdata = exp_hi_reg;
            REG_EXP_LEN: prdata = DATA_W'(exp_len_reg);
            REG_TIMEOUT: prdata = DATA_W'(tmo_reg);
            default:     prdata = '0;
        endcase
    end

    // effective length, cut short at the first NUL byte
    always_comb
    begin
        lim = (exp_len_reg > LEN_W'(EXP_SLOTS)) ? LEN_W'(EXP_SLOTS) : exp_len_reg;
        eff_len_next = lim;
        for (int k = EXP_SLOTS - 1; k >= 0; k--)
        begin
            if ((LEN_W'(k) < lim) && (exp_b[k] == 8'h00))
                eff_len_next = LEN_W'(k);
        end
    end

    // pattern reversed so slot 0 lines up with the newest byte
    always_comb
    begin
        pat_next  = '0;
        mask_next = '0;
        src_idx   = '0;
        for (int i = 0; i < EXP_SLOTS; i++)
        begin
            src_idx = eff_len_next - LEN_W'(i + 1);
            if (LEN_W'(i) < eff_len_next)
            begin
                pat_next[i]  = exp_b[src_idx[3:0]];
                mask_next[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_len_reg <= '0;
            mask_reg    <= '0;
        end
        else
        begin
            eff_len_reg <= eff_len_next;
            mask_reg    <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    assign cfg.pat_rev = pat_reg;
    assign cfg.mask    = mask_reg;
    assign cfg.eff_len = eff_len_reg;
    assign cfg.timeout = tmo_reg;

endmodule

`default_nettype wire

>>> rtl/atrm_front.sv
`default_nettype none

module atrm_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    atrm_item_if.sink        items,
    input  wire logic        pop,
    output atrm_pkg::q_head_t head
);
    import atrm_pkg::*;

    item_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              push;
    logic              do_pop;
    item_t             cls;

    assign items.ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push        = items.valid && items.ready;
    assign do_pop      = pop && (cnt_reg != '0);

    // classify the incoming transfer
    always_comb
    begin
        cls.rx_byte = items.rx_byte;
        case (items.op)
            OP_RESTART: cls.kind = K_RESTART;
            OP_BYTE:    cls.kind = K_BYTE;
            OP_TICK:    cls.kind = K_TICK;
            default:    cls.kind = K_NOP;
        endcase
    end

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

    assign head.valid = (cnt_reg != '0);
    assign head.item  = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> rtl/atrm_back.sv
`default_nettype none

`include "at_response_matcher_top_macros.svh"

module atrm_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire atrm_pkg::cfg_t    cfg,
    input  wire atrm_pkg::q_head_t head,
    output logic                   pop,
    atrm_result_if.source          results
);
    import atrm_pkg::*;

    win_t               win_reg;
    win_t               win_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [TICK_W-1:0]  ela_reg;
    logic [TICK_W-1:0]  ela_next;
    logic [TICK_W-1:0]  ela_inc;
    verdict_t           held_reg;
    verdict_t           held_next;
    logic               nul_reg;
    logic               nul_next;
    logic               ov_reg;
    logic               ov_next;
    verdict_t           verdict_reg;
    logic [SHOWN_W-1:0] shown_reg;
    logic [SHOWN_W-1:0] shown_next;

    win_t               sh_win;
    logic [CNT_W-1:0]   sh_cnt;
    logic               sh_nul;
    logic               exp_hit;
    logic               crlf_hit;
    logic               cme_hit;
    logic               cms_hit;

    // take the next item whenever the output register is free or draining
    assign pop = head.valid && (!ov_reg || results.ready);

    // byte stored into the window unless capacity is reached
    always_comb
    begin
        sh_win = win_reg;
        sh_cnt = cnt_reg;
        sh_nul = nul_reg;
        if (cnt_reg < CNT_W'(CAPACITY))
        begin
            sh_win = {win_reg[WIN_DEPTH-2:0], head.item.rx_byte};
            sh_cnt = cnt_reg + 1'b1;
            if (head.item.rx_byte == 8'h00)
                sh_nul = 1'b1;
        end
    end

    // tail compares on the updated window, all slots in parallel
    always_comb
    begin
        exp_hit  = (CMP_W'(sh_cnt) >= CMP_W'(cfg.eff_len));
        crlf_hit = (CMP_W'(sh_cnt) >= CMP_W'(ERR_CRLF_LEN));
        cme_hit  = (CMP_W'(sh_cnt) >= CMP_W'(ERR_CMX_LEN));
        cms_hit  = cme_hit;
        for (int i = 0; i < EXP_SLOTS; i++)
        begin
            if (cfg.mask[i] && (sh_win[i] != cfg.pat_rev[i]))
                exp_hit = 1'b0;
        end
        for (int i = 0; i < ERR_CRLF_LEN; i++)
        begin
            if (sh_win[i] != ERR_CRLF[ERR_CRLF_LEN-1-i])
                crlf_hit = 1'b0;
        end
        for (int i = 0; i < ERR_CMX_LEN; i++)
        begin
            if (sh_win[i] != ERR_CME[ERR_CMX_LEN-1-i])
                cme_hit = 1'b0;
            if (sh_win[i] != ERR_CMS[ERR_CMX_LEN-1-i])
                cms_hit = 1'b0;
        end
    end

    // saturating tick count
    assign ela_inc = (ela_reg == '1) ? ela_reg : ela_reg + 1'b1;

    // state update for the item at the queue head
    always_comb
    begin
        win_next  = win_reg;
        cnt_next  = cnt_reg;
        ela_next  = ela_reg;
        held_next = held_reg;
        nul_next  = nul_reg;
        case (head.item.kind)
            K_RESTART:
            begin
                win_next  = '0;
                cnt_next  = '0;
                ela_next  = '0;
                nul_next  = 1'b0;
                held_next = (cfg.timeout == '0) ? V_TIMEOUT : V_PENDING;
            end
            K_BYTE:
            begin
                if (held_reg == V_PENDING)
                begin
                    if (ela_reg >= cfg.timeout)
                        held_next = V_TIMEOUT;
                    else
                    begin
                        win_next = sh_win;
                        cnt_next = sh_cnt;
                        nul_next = sh_nul;
                        if (cfg.eff_len == '0)
                            held_next = V_FOUND;
                        else if (!sh_nul)
                        begin
                            if (exp_hit)
                                held_next = V_FOUND;
                            else if (crlf_hit || cme_hit || cms_hit)
                                held_next = V_ERROR;
                        end
                    end
                end
            end
            K_TICK:
            begin
                if (held_reg == V_PENDING)
                begin
                    ela_next = ela_inc;
                    if (ela_inc >= cfg.timeout)
                        held_next = V_TIMEOUT;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_comb
    begin
        ov_next    = ov_reg;
        shown_next = (cnt_next > CNT_W'(SHOWN_MAX)) ? SHOWN_W'(SHOWN_MAX) : SHOWN_W'(cnt_next);
        if (pop)
            ov_next = 1'b1;
        else if (results.ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            cnt_reg  <= '0;
            ela_reg  <= '0;
            held_reg <= V_PENDING;
            nul_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            if (pop)
            begin
                win_reg  <= win_next;
                cnt_reg  <= cnt_next;
                ela_reg  <= ela_next;
                held_reg <= held_next;
                nul_reg  <= nul_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            verdict_reg <= held_next;
            shown_reg   <= shown_next;
        end
    end

    assign results.valid        = ov_reg;
    assign results.verdict      = verdict_reg;
    assign results.stored_bytes = shown_reg;

    // checks
    `ATRM_ASSERT_NEXT(a_held_sticks,
        pop && (head.item.kind != K_RESTART) && (held_reg != V_PENDING),
        held_reg == $past(held_reg), "verdict changed after it was settled")
    `ATRM_ASSERT_SAME(a_cnt_cap, 1'b1, cnt_reg <= CNT_W'(CAPACITY),
        "stored byte count beyond capacity")
    `ATRM_ASSERT_NEXT(a_restart_clears, pop && (head.item.kind == K_RESTART),
        (cnt_reg == '0) && (ela_reg == '0) && !nul_reg, "restart left state behind")
    `ATRM_ASSERT_NEXT(a_result_tracks, pop,
        ov_reg && (verdict_reg == held_reg), "result does not show the held verdict")

endmodule

`default_nettype wire

>>> rtl/at_response_matcher_top.sv
`default_nettype none

// Channel   Dir   Payload                          Transfer when
// items     in    op[1:0], rx_byte[7:0]            items.valid & items.ready
// results   out   verdict[1:0], stored_bytes[8:0]  results.valid & results.ready
// apb       in    paddr[4:0], pwdata/prdata[63:0]  psel & penable & pwrite (write)
//
// One item per cycle sustained while results are taken; each item waits in the two-entry queue
// and its result is registered as it leaves.
// The back end's combinational window compare sets the rate.
// Timeout writes reach the matcher straight from their register; the expected string and
// length pass through a second register (pattern, mask, effective length) after the write.
// rst_n clears all control state asynchronously; the registers return to defaults.
// A stalled result blocks the back end only; the queue keeps taking items until full.

module at_response_matcher_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    atrm_item_if.sink                        items,
    atrm_result_if.source                    results,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [atrm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [atrm_pkg::DATA_W-1:0] pwdata,
    output logic      [atrm_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import atrm_pkg::*;

    cfg_t    cfg;
    q_head_t head;
    logic    pop;

    atrm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    atrm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .items (items),
        .pop   (pop),
        .head  (head)
    );

    atrm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import atrm_pkg::*;

    localparam logic [1:0] OP_IDLE = 2'd3;   // unused op code, block reports current state
    localparam int WIN_LEN     = 16;
    localparam int STORE_LIMIT = 511;
    localparam int RAND_ITEMS  = 550;
    localparam int SETTLE      = 4;

    // Predicts the verdict and stored count for every accepted transfer
    class verdict_board;
        typedef struct packed {
            logic [1:0]         verdict;
            logic [SHOWN_W-1:0] stored;
        } reply_t;

        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [4:0]  pat_len;
        logic [31:0] tick_limit;

        logic [7:0]  win [WIN_LEN];   // index 0 is the newest byte
        int unsigned stored;
        logic [31:0] ticks;
        verdict_t    held;
        bit          blinded;
        reply_t      due_replies[$];

        function new();
            pat_lo     = '0;
            pat_hi     = '0;
            pat_len    = 5'd2;
            tick_limit = 32'd1000;
            restart();
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                REG_EXP_LO:  pat_lo = val;
                REG_EXP_HI:  pat_hi = val;
                REG_EXP_LEN: pat_len = val[4:0];
                default:     tick_limit = val[31:0];
            endcase
        endfunction

        function logic [7:0] pat_byte(int k);
            return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
        endfunction

        // length capped at 16 and cut at the first zero byte
        function int pat_width();
            int lim;
            lim = (pat_len > 16) ? 16 : int'(pat_len);
            for (int k = 0; k < lim; k++)
                if (pat_byte(k) == 8'h00)
                    return k;
            return lim;
        endfunction

        // does the pattern end at the newest stored byte
        function bit tail_is(logic [7:0] pat [WIN_LEN], int len);
            if (stored < len)
                return 1'b0;
            for (int i = 0; i < len; i++)
                if (win[i] != pat[len-1-i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function bit tail_text(string s);
            logic [7:0] pat [WIN_LEN];
            for (int i = 0; i < s.len(); i++)
                pat[i] = s[i];
            return tail_is(pat, s.len());
        endfunction

        function void restart();
            foreach (win[i])
                win[i] = 8'h00;
            stored  = 0;
            ticks   = '0;
            blinded = 1'b0;
            held    = (tick_limit == 0) ? V_TIMEOUT : V_PENDING;
        endfunction

        function void take_rx(logic [7:0] b);
            logic [7:0] pat [WIN_LEN];
            int len;
            if (ticks >= tick_limit) begin
                held = V_TIMEOUT;
                return;
            end
            // full store: byte dropped, checks rerun on the same window
            if (stored < STORE_LIMIT) begin
                for (int i = WIN_LEN - 1; i > 0; i--)
                    win[i] = win[i-1];
                win[0] = b;
                stored++;
                if (b == 8'h00)
                    blinded = 1'b1;
            end
            len = pat_width();
            if (len == 0) begin
                held = V_FOUND;
                return;
            end
            if (blinded)
                return;
            for (int k = 0; k < len; k++)
                pat[k] = pat_byte(k);
            if (tail_is(pat, len))
                held = V_FOUND;
            else if (tail_text("\r\nERROR\r\n") || tail_text("+CME ERROR") ||
                     tail_text("+CMS ERROR"))
                held = V_ERROR;
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] b);
            reply_t r;
            case (op)
                OP_RESTART: restart();
                OP_BYTE:
                    if (held == V_PENDING)
                        take_rx(b);
                OP_TICK:
                    if (held == V_PENDING) begin
                        if (ticks != 32'hFFFF_FFFF)
                            ticks = ticks + 32'd1;
                        if (ticks >= tick_limit)
                            held = V_TIMEOUT;
                    end
                default: ;
            endcase
            r.verdict = held;
            r.stored  = (stored > STORE_LIMIT) ? SHOWN_W'(STORE_LIMIT) : SHOWN_W'(stored);
            due_replies.push_back(r);
        endfunction

        // returns an empty string when the result agrees
        function string check_reply(logic [1:0] verdict, logic [SHOWN_W-1:0] count);
            reply_t r;
            string s;
            s = "";
            if (due_replies.size() == 0)
                return $sformatf("result with nothing pending: verdict %0d stored %0d",
                                 verdict, count);
            r = due_replies.pop_front();
            if (verdict !== r.verdict)
                s = {s, $sformatf("verdict %0d, predicted %0d ", verdict, r.verdict)};
            if (count !== r.stored)
                s = {s, $sformatf("stored_bytes %0d, predicted %0d", count, r.stored)};
            return s;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    atrm_item_if   item_ch ();
    atrm_result_if result_ch ();

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    verdict_board board;
    int           mismatches = 0;
    int           counted_items = 0;
    bit           gaps_on = 1'b0;
    bit           stalls_on = 1'b0;
    logic [7:0]   want [WIN_LEN];
    int           want_len = 1;

    always #6 clk = ~clk;

    at_response_matcher_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // result side: check every transfer against the oldest prediction
    always @(posedge clk)
    begin : result_check
        string msg;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            msg = board.check_reply(result_ch.verdict, result_ch.stored_bytes);
            if (msg != "")
                report(msg);
        end
    end

    // result side back-pressure in bursts
    initial
    begin
        result_ch.ready <= 1'b1;
        forever begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 7) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // one transfer on the item channel; entered and left at a falling edge
    task automatic push_item(logic [1:0] op, logic [7:0] rx);
        bit live;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.op      <= op;
        item_ch.rx_byte <= rx;
        do
            @(posedge clk);
        while (!item_ch.ready);
        live = (op == OP_RESTART) || (board.held == V_PENDING);
        board.note_item(op, rx);
        if (live)
            counted_items++;
        @(negedge clk);
    endtask

    // received byte with the odd tick or idle op slipped in ahead
    task automatic send_rx(logic [7:0] b);
        if ($urandom_range(0, 7) == 0)
            push_item(OP_TICK, 8'($urandom));
        if ($urandom_range(0, 30) == 0)
            push_item(OP_IDLE, 8'($urandom));
        push_item(OP_BYTE, b);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_rx(s[i]);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // wait for every predicted result, then let the pipeline empty
    task automatic settle();
        int guard;
        guard = 0;
        item_ch.valid <= 1'b0;
        while (board.due_replies.size() != 0 && guard < 5000) begin
            @(negedge clk);
            guard++;
        end
        if (board.due_replies.size() != 0) begin
            report($sformatf("%0d results never arrived", board.due_replies.size()));
            board.due_replies.delete();
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                             logic [31:0] tmo);
        settle();
        apb_write(REG_EXP_LO, lo);
        apb_write(REG_EXP_HI, hi);
        apb_write(REG_EXP_LEN, {59'd0, len});
        apb_write(REG_TIMEOUT, {32'd0, tmo});
        // let the settings pass through to the matcher before sending items
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [7:0] noise();
        return ($urandom_range(0, 39) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    endfunction

    function automatic string error_text(int which);
        case (which)
            0:       return "\r\nERROR\r\n";
            1:       return "+CME ERROR";
            default: return "+CMS ERROR";
        endcase
    endfunction

    // new expected string, length setting and tick limit
    task automatic configure_random();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [31:0] tmo;
        bit          printable;
        case ($urandom_range(0, 7))
            0:       want_len = 1;
            1:       want_len = 16;
            default: want_len = $urandom_range(1, 16);
        endcase
        printable = $urandom_range(0, 1);
        for (int k = 0; k < WIN_LEN; k++)
            want[k] = printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(1, 255));
        // a zero inside the string cuts it short
        if ($urandom_range(0, 9) == 0)
            want[$urandom_range(0, want_len - 1)] = 8'h00;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        for (int k = 0; k < want_len; k++)
            if (k < 8)
                lo[8*k +: 8] = want[k];
            else
                hi[8*(k-8) +: 8] = want[k];
        case ($urandom_range(0, 9))
            0:       len = 5'd0;
            1:       len = 5'($urandom_range(17, 31));
            2:       len = 5'd16;
            default: len = 5'(want_len);
        endcase
        case ($urandom_range(0, 11))
            0:       tmo = 32'd0;
            1:       tmo = 32'd1;
            2:       tmo = 32'hFFFF_FFFF;
            3:       tmo = $urandom;
            4, 5:    tmo = $urandom_range(2, 8);
            default: tmo = $urandom_range(20, 200);
        endcase
        configure(lo, hi, len, tmo);
    endtask

    // one reply, mostly after a restart: mostly well formed, some broken
    task automatic run_sequence();
        string s;
        int    cut;
        if ($urandom_range(0, 7) != 0)
            push_item(OP_RESTART, 8'($urandom));
        repeat ($urandom_range(0, 5)) send_rx(noise());
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                for (int k = 0; k < want_len; k++)
                    send_rx(want[k]);
            4, 5:
                send_text(error_text($urandom_range(0, 2)));
            6:
                repeat ((board.tick_limit <= 60) ? board.tick_limit + 1 : 20)
                    push_item(OP_TICK, 8'($urandom));
            7: begin
                // expected string with one byte missing
                cut = $urandom_range(0, want_len - 1);
                for (int k = 0; k < want_len; k++)
                    if (k != cut)
                        send_rx(want[k]);
            end
            8: begin
                // error reply with one character spoilt
                s = error_text($urandom_range(0, 2));
                s.putc($urandom_range(0, s.len() - 1), "x");
                send_text(s);
            end
            default: begin
                send_rx(8'h00);
                for (int k = 0; k < want_len; k++)
                    send_rx(want[k]);
            end
        endcase
        repeat ($urandom_range(0, 3)) send_rx(noise());
    endtask

    initial
    begin
        #5_000_000;
        $display("[at_response_matcher_top] ERROR");
        $finish;
    end

    initial
    begin
        logic [63:0] tail_lo;
        string       s;
        board = new();
        rst_n           <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.op      <= OP_RESTART;
        item_ch.rx_byte <= 8'h00;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        // reset registers give an empty expected string: first byte is a find
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_IDLE, 8'h00);
        push_item(OP_RESTART, 8'hA5);
        push_item(OP_TICK, 8'h5A);
        push_item(OP_TICK, 8'hC3);
        // "OK" with a tick limit already passed mid-wait: byte gives timeout
        configure(64'hFFFF_FFFF_FFFF_4B4F, 64'h0, 5'd2, 32'd2);
        push_item(OP_BYTE, 8'h4F);
        // NUL blinds the match, then ticks run out
        push_item(OP_RESTART, 8'h00);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'h4F);
        push_item(OP_BYTE, 8'h4B);
        push_item(OP_TICK, 8'h00);
        push_item(OP_TICK, 8'hFF);
        // error reply, then a byte after the verdict is held
        push_item(OP_RESTART, 8'h00);
        s = "+CMS ERROR";
        for (int i = 0; i < s.len(); i++)
            push_item(OP_BYTE, s[i]);
        push_item(OP_BYTE, 8'h4F);
        // zero tick limit: restart times out at once
        configure(64'hFFFF_FFFF_FFFF_4B4F, 64'h0, 5'd2, 32'd0);
        push_item(OP_RESTART, 8'h00);
        push_item(OP_BYTE, 8'h4F);

        // random phases
        counted_items = 0;
        while (counted_items < RAND_ITEMS) begin
            configure_random();
            repeat ($urandom_range(2, 5)) run_sequence();
        end

        // fill the store past capacity with no idling on either side
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        configure(64'h4847_4645_4443_4241, 64'h504F_4E4D_4C4B_4A49, 5'd16, 32'hFFFF_FFFF);
        push_item(OP_RESTART, 8'h00);
        repeat (STORE_LIMIT + 4) begin
            if ($urandom_range(0, 29) == 0)
                push_item(OP_TICK, 8'($urandom));
            push_item(OP_BYTE, 8'($urandom_range(97, 122)));
        end
        // new string equal to the last four stored bytes: found on a dropped byte
        tail_lo = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   board.win[0], board.win[1], board.win[2], board.win[3]};
        configure(tail_lo, 64'h504F_4E4D_4C4B_4A49, 5'd4, 32'hFFFF_FFFF);
        push_item(OP_BYTE, 8'h71);
        push_item(OP_TICK, 8'h00);
        push_item(OP_RESTART, 8'h00);
        push_item(OP_BYTE, 8'h00);

        settle();
        if (mismatches == 0)
            $display("[at_response_matcher_top] OK");
        else
            $display("[at_response_matcher_top] ERROR");
        $finish;
    end

endmodule
